@@ rtl/huffman_tree_bit_decoder_core_defines.svh @@
// ----------------------------------------------------------------------------
// Huffman tree bit decoder - assertion macros
// Shared property wrappers, clocked on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_TREE_BIT_DECODER_CORE_DEFINES_SVH
`define HUFFMAN_TREE_BIT_DECODER_CORE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define HTBD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition never holds
`define HTBD_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

@@ rtl/htbd_pkg.sv @@
// ----------------------------------------------------------------------------
// Huffman tree bit decoder - package
// Token, mode, error and command codes plus the word types between stages.
// ----------------------------------------------------------------------------
package htbd_pkg;

    localparam int NODE_COUNT_DEF  = 512;
    localparam int STACK_DEPTH_DEF = 256;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [7:0] TOK_EMPTY = 8'h30;
    localparam logic [7:0] TOK_LEAF  = 8'h31;
    localparam logic [7:0] TOK_INNER = 8'h32;

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_BIT   = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    typedef logic [2:0] t_err;
    localparam t_err ERR_NONE        = 3'd0;
    localparam t_err ERR_EMPTY_CHILD = 3'd1;
    localparam t_err ERR_BAD_TOKEN   = 3'd2;
    localparam t_err ERR_OVERFLOW    = 3'd3;
    localparam t_err ERR_BIT_EARLY   = 3'd4;
    localparam t_err ERR_TOKEN_LATE  = 3'd5;

    typedef logic [2:0] t_op;
    localparam t_op OP_TOK_EMPTY = 3'd0;
    localparam t_op OP_TOK_LEAF  = 3'd1;
    localparam t_op OP_TOK_INNER = 3'd2;
    localparam t_op OP_TOK_BAD   = 3'd3;
    localparam t_op OP_BIT       = 3'd4;
    localparam t_op OP_CLEAR     = 3'd5;
    localparam t_op OP_NOP       = 3'd6;

    typedef struct packed {
        t_op        op;
        logic [7:0] data_byte;
        logic       code_bit;
    } t_cmd;

    typedef struct packed {
        logic       symbol_valid;
        logic [7:0] symbol;
        t_err       error_code;
        logic       mid_code;
        logic       tree_ready;
    } t_res;

endpackage

@@ rtl/huffman_tree_bit_decoder_core.sv @@
// ----------------------------------------------------------------------------
// Huffman tree bit decoder - top level
// Loads a preorder Huffman tree into a node table, then decodes one code
// bit per word by walking the table from the root.
//
// Channel   Handshake      Words carry
// input     push / full    i_mode, i_data_byte, i_code_bit
// result    empty / pop    o_symbol_valid, o_symbol, o_error_code, o_mid_code,
//                          o_tree_ready
//
// The executor takes one word at a time: the node-table read for a code
// bit, then the leaf test on the returned entry (loads: node write, then the
// parent link or stack pop).
// One result word per input word, in order.
// Synchronous reset clears control state only; no clearing pass on memories.
// full rises when the command queue holds QUEUE_DEPTH words; the executor
// holds its finishing step while the result queue is full.
// ----------------------------------------------------------------------------
`include "huffman_tree_bit_decoder_core_defines.svh"

module huffman_tree_bit_decoder_core #(
    parameter int NODE_COUNT  = htbd_pkg::NODE_COUNT_DEF,
    parameter int STACK_DEPTH = htbd_pkg::STACK_DEPTH_DEF,
    parameter int QUEUE_DEPTH = htbd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] i_mode,
    input  logic [7:0] i_data_byte,
    input  logic       i_code_bit,
    output logic       empty,
    input  logic       pop,
    output logic       o_symbol_valid,
    output logic [7:0] o_symbol,
    output logic [2:0] o_error_code,
    output logic       o_mid_code,
    output logic       o_tree_ready
);

    htbd_pkg::t_cmd                    w_cmd;
    logic                              w_cmd_valid, w_cmd_take;
    htbd_pkg::t_res                    w_res, w_head;
    logic                              w_res_push, w_res_full;
    logic [$bits(htbd_pkg::t_res)-1:0] w_q;

    htbd_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_mode      (i_mode),
        .i_data_byte (i_data_byte),
        .i_code_bit  (i_code_bit),
        .o_full      (full),
        .o_cmd       (w_cmd),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_take  (w_cmd_take)
    );

    htbd_back #(
        .NODE_COUNT  (NODE_COUNT),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_take  (w_cmd_take),
        .o_res       (w_res),
        .o_res_push  (w_res_push),
        .i_res_full  (w_res_full)
    );

    htbd_fifo #(
        .WIDTH ($bits(htbd_pkg::t_res)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (w_q),
        .o_empty (empty)
    );

    assign w_head         = htbd_pkg::t_res'(w_q);
    assign o_symbol_valid = w_head.symbol_valid;
    assign o_symbol       = w_head.symbol;
    assign o_error_code   = w_head.error_code;
    assign o_mid_code     = w_head.mid_code;
    assign o_tree_ready   = w_head.tree_ready;

    `HTBD_ASSERT_IMPL(a_sym_err, !empty && o_symbol_valid,
        (o_error_code == htbd_pkg::ERR_NONE) || (o_error_code == htbd_pkg::ERR_EMPTY_CHILD),
        "symbol word with load error")
    `HTBD_ASSERT_NEVER(a_sym_mid, !empty && o_symbol_valid && o_mid_code,
        "walk not at root after symbol")
    `HTBD_ASSERT_IMPL(a_bit_early, !empty && (o_error_code == htbd_pkg::ERR_BIT_EARLY),
        !o_tree_ready, "early bit with tree ready")
    `HTBD_ASSERT_IMPL(a_tok_late, !empty && (o_error_code == htbd_pkg::ERR_TOKEN_LATE),
        o_tree_ready, "late token without tree ready")

endmodule

@@ rtl/htbd_fifo.sv @@
// ----------------------------------------------------------------------------
// Huffman tree bit decoder - word queue
// Small register queue, registered head; push+pop share a cycle unless full or empty.
// ----------------------------------------------------------------------------
module htbd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = htbd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr, r_rptr;
    logic [CW-1:0]    r_count;
    logic             w_push, w_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CW'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

@@ rtl/htbd_front.sv @@
// ----------------------------------------------------------------------------
// Huffman tree bit decoder - front end
// Accepts input words, decodes mode and token into a command, queues it.
// ----------------------------------------------------------------------------
module htbd_front #(
    parameter int QUEUE_DEPTH = htbd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  logic [1:0]      i_mode,
    input  logic [7:0]      i_data_byte,
    input  logic            i_code_bit,
    output logic            o_full,
    output htbd_pkg::t_cmd  o_cmd,
    output logic            o_cmd_valid,
    input  logic            i_cmd_take
);

    htbd_pkg::t_cmd                   w_cmd;
    logic [$bits(htbd_pkg::t_cmd)-1:0] w_q;
    logic                             w_empty;

    always_comb begin
        w_cmd.data_byte = i_data_byte;
        w_cmd.code_bit  = i_code_bit;
        unique case (i_mode)
            htbd_pkg::MODE_LOAD: begin
                unique case (i_data_byte)
                    htbd_pkg::TOK_EMPTY: w_cmd.op = htbd_pkg::OP_TOK_EMPTY;
                    htbd_pkg::TOK_LEAF:  w_cmd.op = htbd_pkg::OP_TOK_LEAF;
                    htbd_pkg::TOK_INNER: w_cmd.op = htbd_pkg::OP_TOK_INNER;
                    default:             w_cmd.op = htbd_pkg::OP_TOK_BAD;
                endcase
            end
            htbd_pkg::MODE_BIT:   w_cmd.op = htbd_pkg::OP_BIT;
            htbd_pkg::MODE_CLEAR: w_cmd.op = htbd_pkg::OP_CLEAR;
            default:              w_cmd.op = htbd_pkg::OP_NOP;
        endcase
    end

    htbd_fifo #(
        .WIDTH ($bits(htbd_pkg::t_cmd)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (w_cmd),
        .o_full  (o_full),
        .i_pop   (i_cmd_take),
        .o_data  (w_q),
        .o_empty (w_empty)
    );

    assign o_cmd       = htbd_pkg::t_cmd'(w_q);
    assign o_cmd_valid = !w_empty;

endmodule

@@ rtl/htbd_back.sv @@
// ----------------------------------------------------------------------------
// Huffman tree bit decoder - executor
// Command engine: tree loader with pending-slot stack, and the
// node-table walk for code bits. Node table split into left, right and
// symbol memories so a parent link is a plain write.
// ----------------------------------------------------------------------------
module htbd_back #(
    parameter int NODE_COUNT  = htbd_pkg::NODE_COUNT_DEF,
    parameter int STACK_DEPTH = htbd_pkg::STACK_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  htbd_pkg::t_cmd  i_cmd,
    input  logic            i_cmd_valid,
    output logic            o_cmd_take,
    output htbd_pkg::t_res  o_res,
    output logic            o_res_push,
    input  logic            i_res_full
);

    localparam int NW  = $clog2(NODE_COUNT);
    localparam int NCW = $clog2(NODE_COUNT + 1);
    localparam int SW  = $clog2(STACK_DEPTH);
    localparam int SCW = $clog2(STACK_DEPTH + 1);
    localparam int SLW = $clog2(2 * NODE_COUNT + 1);

    localparam logic [1:0] PH_TOKEN    = 2'd0;
    localparam logic [1:0] PH_LEAFBYTE = 2'd1;
    localparam logic [1:0] PH_READY    = 2'd2;

    // child link: {present, index}
    logic [NW:0]   r_lmem [NODE_COUNT];
    logic [NW:0]   r_rmem [NODE_COUNT];
    logic [7:0]    r_smem [NODE_COUNT];
    logic [NW-1:0] r_stk  [STACK_DEPTH];

    logic [1:0]     r_phase, n_phase;
    logic [SCW-1:0] r_scount, n_scount;
    logic [NCW-1:0] r_nfn, n_nfn;
    logic [SLW-1:0] r_slot, n_slot;
    logic [NW-1:0]  r_walk, n_walk;
    logic           r_busy, n_busy;

    logic [NW:0]    r_root_l, r_root_r, r_cur_l, r_cur_r;
    logic           r_par, r_pop, r_dec;
    logic [NW-1:0]  r_par_idx, r_target;
    logic           r_par_side;
    htbd_pkg::t_err r_err;
    logic [NW:0]    r_ld, r_rd;
    logic [7:0]     r_sd;
    logic [NW-1:0]  r_stk_q;

    logic           w_take, w_fin;
    logic           w_alloc, w_pop, w_push, w_leafbyte, w_dec, w_clear, w_to_leaf, w_walk0;
    htbd_pkg::t_err w_err;
    logic [NW-1:0]  w_nfn_idx, w_par_idx;
    logic [NCW-1:0] w_nfn_m1;
    logic [SCW-1:0] w_scount_m1;
    logic [SLW-1:0] w_slot_m1;
    logic           w_par_side, w_tab_full, w_stk_full;
    logic [NW:0]    w_cur_l, w_cur_r;
    logic           w_has;
    logic [NW-1:0]  w_child, w_target;
    logic           w_leaf;
    logic [NW-1:0]  w_walk_fin;

    logic           w_l_we, w_r_we, w_s_we, w_k_we;
    logic [NW-1:0]  w_l_wa, w_r_wa, w_s_wa;
    logic [NW:0]    w_l_wd, w_r_wd;
    logic [7:0]     w_s_wd;
    logic [SW-1:0]  w_k_wa;

    assign w_take      = i_cmd_valid && !r_busy;
    assign w_fin       = r_busy && !i_res_full;
    assign o_cmd_take  = w_take;

    assign w_nfn_idx   = r_nfn[NW-1:0];
    assign w_nfn_m1    = r_nfn - NCW'(1);
    assign w_scount_m1 = r_scount - SCW'(1);
    assign w_slot_m1   = r_slot - SLW'(1);
    assign w_par_idx   = w_slot_m1[NW:1];
    assign w_par_side  = w_slot_m1[0];
    assign w_tab_full  = (r_nfn == NCW'(NODE_COUNT));
    assign w_stk_full  = (r_scount == SCW'(STACK_DEPTH));

    assign w_cur_l  = (r_walk == '0) ? r_root_l : r_cur_l;
    assign w_cur_r  = (r_walk == '0) ? r_root_r : r_cur_r;
    assign w_has    = i_cmd.code_bit ? w_cur_r[NW] : w_cur_l[NW];
    assign w_child  = i_cmd.code_bit ? w_cur_r[NW-1:0] : w_cur_l[NW-1:0];
    assign w_target = w_has ? w_child : '0;

    assign w_leaf     = !r_ld[NW] && !r_rd[NW];
    assign w_walk_fin = r_dec ? (w_leaf ? '0 : r_target) : r_walk;

    // take step: classify against the loader phase
    always_comb begin
        w_alloc    = 1'b0;
        w_pop      = 1'b0;
        w_push     = 1'b0;
        w_leafbyte = 1'b0;
        w_dec      = 1'b0;
        w_clear    = 1'b0;
        w_to_leaf  = 1'b0;
        w_walk0    = 1'b0;
        w_err      = htbd_pkg::ERR_NONE;
        if (w_take) begin
            unique case (i_cmd.op)
                htbd_pkg::OP_TOK_EMPTY, htbd_pkg::OP_TOK_LEAF,
                htbd_pkg::OP_TOK_INNER, htbd_pkg::OP_TOK_BAD: begin
                    priority if (r_phase == PH_READY) begin
                        w_err = htbd_pkg::ERR_TOKEN_LATE;
                    end else if (r_phase == PH_LEAFBYTE) begin
                        w_leafbyte = 1'b1;
                        w_pop      = 1'b1;
                    end else if (i_cmd.op == htbd_pkg::OP_TOK_EMPTY) begin
                        w_pop = 1'b1;
                    end else if (w_tab_full) begin
                        w_err = htbd_pkg::ERR_OVERFLOW;
                    end else if (i_cmd.op == htbd_pkg::OP_TOK_LEAF) begin
                        w_alloc   = 1'b1;
                        w_to_leaf = 1'b1;
                    end else if (i_cmd.op == htbd_pkg::OP_TOK_INNER) begin
                        if (w_stk_full) begin
                            w_err = htbd_pkg::ERR_OVERFLOW;
                        end else begin
                            w_alloc = 1'b1;
                            w_push  = 1'b1;
                        end
                    end else begin
                        w_alloc = 1'b1;
                        w_pop   = 1'b1;
                        w_err   = htbd_pkg::ERR_BAD_TOKEN;
                    end
                end
                htbd_pkg::OP_BIT: begin
                    if (r_phase != PH_READY) begin
                        w_err = htbd_pkg::ERR_BIT_EARLY;
                    end else if (r_nfn == '0) begin
                        w_err   = htbd_pkg::ERR_EMPTY_CHILD;
                        w_walk0 = 1'b1;
                    end else begin
                        w_dec = 1'b1;
                        w_err = w_has ? htbd_pkg::ERR_NONE : htbd_pkg::ERR_EMPTY_CHILD;
                    end
                end
                htbd_pkg::OP_CLEAR: w_clear = 1'b1;
                default: ;
            endcase
        end
    end

    // state update and memory write ports
    always_comb begin
        n_phase  = r_phase;
        n_scount = r_scount;
        n_nfn    = r_nfn;
        n_slot   = r_slot;
        n_walk   = r_walk;
        n_busy   = r_busy;
        w_l_we   = 1'b0;
        w_l_wa   = w_nfn_idx;
        w_l_wd   = '0;
        w_r_we   = 1'b0;
        w_r_wa   = w_nfn_idx;
        w_r_wd   = '0;
        w_s_we   = 1'b0;
        w_s_wa   = w_nfn_idx;
        w_s_wd   = '0;
        w_k_we   = 1'b0;
        w_k_wa   = r_scount[SW-1:0];

        if (w_take) begin
            n_busy = 1'b1;
        end else if (w_fin) begin
            n_busy = 1'b0;
        end

        if (w_clear) begin
            n_scount = '0;
            n_nfn    = '0;
            n_slot   = '0;
            n_phase  = PH_TOKEN;
            n_walk   = '0;
        end
        if (w_walk0) begin
            n_walk = '0;
        end
        if (w_alloc) begin
            w_l_we = 1'b1;
            w_r_we = 1'b1;
            w_s_we = 1'b1;
            n_nfn  = r_nfn + NCW'(1);
        end
        if (w_push) begin
            w_k_we   = 1'b1;
            n_scount = r_scount + SCW'(1);
            n_slot   = SLW'({w_nfn_idx, 1'b1});
        end
        if (w_to_leaf) begin
            n_phase = PH_LEAFBYTE;
        end
        if (w_leafbyte) begin
            w_s_we = 1'b1;
            w_s_wa = w_nfn_m1[NW-1:0];
            w_s_wd = i_cmd.data_byte;
        end
        if (w_pop) begin
            if (r_scount != '0) begin
                n_scount = w_scount_m1;
                n_phase  = PH_TOKEN;
            end else begin
                n_phase = PH_READY;
            end
        end

        // finish step: parent link, popped slot, walk step
        if (w_fin) begin
            if (r_par && !r_par_side) begin
                w_l_we = 1'b1;
                w_l_wa = r_par_idx;
                w_l_wd = {1'b1, r_target};
            end
            if (r_par && r_par_side) begin
                w_r_we = 1'b1;
                w_r_wa = r_par_idx;
                w_r_wd = {1'b1, r_target};
            end
            if (r_pop) begin
                n_slot = SLW'({r_stk_q, 1'b0}) + SLW'(2);
            end
            if (r_dec) begin
                n_walk = w_walk_fin;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_l_we) begin
            r_lmem[w_l_wa] <= w_l_wd;
        end
        if (w_dec) begin
            r_ld <= r_lmem[w_target];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_r_we) begin
            r_rmem[w_r_wa] <= w_r_wd;
        end
        if (w_dec) begin
            r_rd <= r_rmem[w_target];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_we) begin
            r_smem[w_s_wa] <= w_s_wd;
        end
        if (w_dec) begin
            r_sd <= r_smem[w_target];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_k_we) begin
            r_stk[w_k_wa] <= w_nfn_idx;
        end
        if (w_pop && (r_scount != '0)) begin
            r_stk_q <= r_stk[w_scount_m1[SW-1:0]];
        end
    end

    // per-word context, root copy and current node copy
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_par      <= w_alloc && (r_slot != '0);
            r_par_idx  <= w_par_idx;
            r_par_side <= w_par_side;
            r_pop      <= w_pop && (r_scount != '0);
            r_dec      <= w_dec;
            r_err      <= w_err;
            r_target   <= w_alloc ? w_nfn_idx : w_target;
        end
        if (w_l_we && (w_l_wa == '0)) begin
            r_root_l <= w_l_wd;
        end
        if (w_r_we && (w_r_wa == '0)) begin
            r_root_r <= w_r_wd;
        end
        if (w_fin && r_dec && !w_leaf) begin
            r_cur_l <= r_ld;
            r_cur_r <= r_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_TOKEN;
            r_scount <= '0;
            r_nfn    <= '0;
            r_slot   <= '0;
            r_walk   <= '0;
            r_busy   <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_scount <= n_scount;
            r_nfn    <= n_nfn;
            r_slot   <= n_slot;
            r_walk   <= n_walk;
            r_busy   <= n_busy;
        end
    end

    always_comb begin
        o_res_push         = w_fin;
        o_res.symbol_valid = r_dec && w_leaf;
        o_res.symbol       = (r_dec && w_leaf) ? r_sd : 8'd0;
        o_res.error_code   = r_err;
        o_res.mid_code     = (w_walk_fin != '0);
        o_res.tree_ready   = (r_phase == PH_READY);
    end

endmodule
